### rtl/tasvm_pkg.sv
// tasvm_pkg: shared constants, field offsets, command and status structs
// for the three-address stack machine executor
// depends on nothing
package tasvm_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 4096;
  localparam int unsigned PC_BITS_DEF     = 16;

  // opcodes
  localparam logic [4:0] OP_GOTO   = 5'd0;
  localparam logic [4:0] OP_LT     = 5'd1;
  localparam logic [4:0] OP_GT     = 5'd2;
  localparam logic [4:0] OP_LE     = 5'd3;
  localparam logic [4:0] OP_GE     = 5'd4;
  localparam logic [4:0] OP_EQ     = 5'd5;
  localparam logic [4:0] OP_NE     = 5'd6;
  localparam logic [4:0] OP_MOVE   = 5'd7;
  localparam logic [4:0] OP_ADD    = 5'd8;
  localparam logic [4:0] OP_SUB    = 5'd9;
  localparam logic [4:0] OP_MUL    = 5'd10;
  localparam logic [4:0] OP_DIV    = 5'd11;
  localparam logic [4:0] OP_SUBREG = 5'd12;
  localparam logic [4:0] OP_ADDREG = 5'd13;
  localparam logic [4:0] OP_IF     = 5'd14;
  localparam logic [4:0] OP_CALL   = 5'd15;
  localparam logic [4:0] OP_IN     = 5'd16;
  localparam logic [4:0] OP_OUT    = 5'd17;
  localparam logic [4:0] OP_RET    = 5'd18;
  localparam logic [4:0] OP_NOP    = 5'd19;
  localparam logic [4:0] OP_PARAM  = 5'd20;
  localparam logic [4:0] OP_ALLOC  = 5'd21;
  localparam logic [4:0] OP_HALT   = 5'd22;

  // source modes
  localparam logic [2:0] MD_IMM    = 3'd0;
  localparam logic [2:0] MD_REG    = 3'd1;
  localparam logic [2:0] MD_ABS    = 3'd2;
  localparam logic [2:0] MD_RV     = 3'd3;
  localparam logic [2:0] MD_RR     = 3'd4;
  localparam logic [2:0] MD_ABSENT = 3'd5;

  // destination modes
  localparam logic [1:0] DM_REG = 2'd0;
  localparam logic [1:0] DM_ABS = 2'd1;
  localparam logic [1:0] DM_RV  = 2'd2;
  localparam logic [1:0] DM_RR  = 2'd3;

  localparam logic [3:0] REGS_MAX = 4'd8;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_HALT  = 3'd1;
  localparam logic [2:0] ST_DIV0  = 3'd2;
  localparam logic [2:0] ST_RANGE = 3'd3;
  localparam logic [2:0] ST_BAD   = 3'd4;

  // operand and address checks, one per cycle
  localparam logic [3:0] CK_NONE = 4'd0;
  localparam logic [3:0] CK_SRCA = 4'd1;
  localparam logic [3:0] CK_SRCB = 4'd2;
  localparam logic [3:0] CK_DST  = 4'd3;
  localparam logic [3:0] CK_SPM1 = 4'd4;
  localparam logic [3:0] CK_SPM2 = 4'd5;
  localparam logic [3:0] CK_SP   = 4'd6;
  localparam logic [3:0] CK_FP   = 4'd7;
  localparam logic [3:0] CK_FP1  = 4'd8;
  localparam logic [3:0] CK_TREG = 4'd9;

  // where a memory read lands
  localparam logic [2:0] TG_NONE = 3'd0;
  localparam logic [2:0] TG_A    = 3'd1;
  localparam logic [2:0] TG_B    = 3'd2;
  localparam logic [2:0] TG_X1   = 3'd3;
  localparam logic [2:0] TG_X2   = 3'd4;

  // input tdata layout
  localparam int unsigned IN_W    = 160;
  localparam int unsigned F_OP    = 0;
  localparam int unsigned F_AM    = 5;
  localparam int unsigned F_AR    = 8;
  localparam int unsigned F_AV    = 12;
  localparam int unsigned F_BM    = 44;
  localparam int unsigned F_BR    = 47;
  localparam int unsigned F_BV    = 51;
  localparam int unsigned F_DM    = 83;
  localparam int unsigned F_DR    = 85;
  localparam int unsigned F_DV    = 89;
  localparam int unsigned F_CON   = 121;

  // output tdata layout
  localparam int unsigned OUT_W   = 56;

  typedef struct packed {
    logic       load;
    logic [3:0] chk;
    logic       calc;
    logic       div_start;
    logic       commit;
    logic       commit2;
    logic       fin_err;
    logic [2:0] err;
    logic       clr_we;
  } dp_cmd_t;

  typedef struct packed {
    logic [4:0] op;
    logic [2:0] a_mode;
    logic       halted;
    logic [2:0] chk_st;
    logic       b_zero;
    logic       div_done;
    logic       clr_last;
  } dp_stat_t;

  // first register of a pair
  function automatic logic [1:0] reg_hi(input logic [3:0] rg);
    logic [1:0] r;
    unique case (rg)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // second register of a pair
  function automatic logic [1:0] reg_lo(input logic [3:0] rg);
    logic [1:0] r;
    unique case (rg)
      4'd0, 4'd3, 4'd6: r = 2'd0;
      4'd1, 4'd4, 4'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

### rtl/tasvm_div.sv
// tasvm_div: signed truncating divider, one quotient bit per cycle
// uses tasvm_pkg for nothing but house consistency of the project
module tasvm_div
  import tasvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dvd,
  input  logic [31:0] dvs,
  output logic        done,
  output logic [31:0] quo
);

  localparam int unsigned NBITS = 32;

  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic        neg_r;
  logic [31:0] q_r;
  logic [31:0] rem_r;
  logic [31:0] d_r;
  logic [32:0] sh;
  logic [33:0] diff;
  logic        ge;

  assign sh   = {rem_r, q_r[31]};
  assign diff = {1'b0, sh} - {2'b00, d_r};
  assign ge   = !diff[33];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(NBITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dvd[31] ? (~dvd + 32'd1) : dvd;
      d_r   <= dvs[31] ? (~dvs + 32'd1) : dvs;
      rem_r <= '0;
      neg_r <= dvd[31] ^ dvs[31];
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= diff[31:0];
        q_r   <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= sh[31:0];
        q_r   <= {q_r[30:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  // magnitude of most negative over minus one stays as is
  assign quo  = neg_r ? (~q_r + 32'd1) : q_r;

endmodule

### rtl/tasvm_dp.sv
// tasvm_dp: datapath with registers, stack memory, address checker, alu
// depends on tasvm_pkg and tasvm_div
module tasvm_dp
  import tasvm_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned PC_BITS     = PC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IN_W-1:0]  in_data,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  output logic [OUT_W-1:0] out_data
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);

  // latched instruction
  logic [4:0]  op_r;
  logic [2:0]  am_r, bm_r;
  logic [3:0]  ar_r, br_r, dr_r;
  logic [31:0] av_r, bv_r, dv_r, con_r;
  logic [1:0]  dm_r;

  // architectural state
  logic [31:0]        acc_r, fp_r, sp_r;
  logic [31:0]        acc_nxt, fp_nxt, sp_nxt;
  logic [PC_BITS-1:0] pc_r, pc_nxt, pc_inc;
  logic               halt_r, halt_nxt;

  // operands and indexes
  logic [31:0]   a_r, b_r, x1_r, x2_r, res_r;
  logic [AW-1:0] idx_d_r, idx1_r, idx2_r;
  logic          to_reg_r;

  // memory
  logic [31:0]   mem [STACK_DEPTH];
  logic [31:0]   rdata_r;
  logic [2:0]    tag_r;
  logic [AW-1:0] clr_cnt_r;

  // check unit
  logic [2:0]    m;
  logic [3:0]    rg;
  logic [31:0]   v;
  logic [31:0]   x, y, dval;
  logic          bad, use_addr, is_read;
  logic [2:0]    rtag;
  logic [33:0]   sum;
  logic          in_rng;
  logic [2:0]    ck_st;
  logic [AW-1:0] idx;

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [31:0]   result;
  logic          fin_ok;
  logic [31:0]   div_q;
  logic          div_done;
  logic [31:0]   tr_val, x2p1;
  logic [1:0]    tr;
  logic [31:0]   pc_ext, npc_ext;

  function automatic logic [31:0] reg_get(input logic [1:0] r, input logic [31:0] a0,
                                          input logic [31:0] a1, input logic [31:0] a2);
    logic [31:0] o;
    unique case (r)
      2'd0:    o = a0;
      2'd1:    o = a1;
      default: o = a2;
    endcase
    return o;
  endfunction

  tasvm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .dvd   (a_r),
    .dvs   (b_r),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_data[F_OP +: 5];
      am_r  <= in_data[F_AM +: 3];
      ar_r  <= in_data[F_AR +: 4];
      av_r  <= in_data[F_AV +: 32];
      bm_r  <= in_data[F_BM +: 3];
      br_r  <= in_data[F_BR +: 4];
      bv_r  <= in_data[F_BV +: 32];
      dm_r  <= in_data[F_DM +: 2];
      dr_r  <= in_data[F_DR +: 4];
      dv_r  <= in_data[F_DV +: 32];
      con_r <= in_data[F_CON +: 32];
    end
  end

  // one signed add and range compare per cycle
  always_comb begin
    m        = am_r;
    rg       = ar_r;
    v        = av_r;
    x        = '0;
    y        = '0;
    dval     = '0;
    bad      = 1'b0;
    use_addr = 1'b0;
    is_read  = 1'b0;
    rtag     = TG_NONE;
    if (cmd.chk == CK_SRCB) begin
      m  = bm_r;
      rg = br_r;
      v  = bv_r;
    end
    unique case (cmd.chk)
      CK_SRCA, CK_SRCB: begin
        rtag = (cmd.chk == CK_SRCA) ? TG_A : TG_B;
        bad  = (m == MD_REG || m == MD_RV || m == MD_RR) && (rg > REGS_MAX);
        unique case (m)
          MD_IMM: dval = v;
          MD_REG: dval = reg_get(reg_hi(rg), acc_r, fp_r, sp_r);
          MD_ABS: begin
            x = v;
            use_addr = 1'b1;
          end
          MD_RV: begin
            x = reg_get(reg_hi(rg), acc_r, fp_r, sp_r);
            y = v;
            use_addr = 1'b1;
          end
          MD_RR: begin
            x = reg_get(reg_hi(rg), acc_r, fp_r, sp_r);
            y = reg_get(reg_lo(rg), acc_r, fp_r, sp_r);
            use_addr = 1'b1;
          end
          default: bad = 1'b1;
        endcase
        is_read = use_addr;
      end
      CK_DST: begin
        bad = (dm_r != DM_ABS) && (dr_r > REGS_MAX);
        unique case (dm_r)
          DM_REG: use_addr = 1'b0;
          DM_ABS: begin
            x = dv_r;
            use_addr = 1'b1;
          end
          DM_RV: begin
            x = reg_get(reg_hi(dr_r), acc_r, fp_r, sp_r);
            y = dv_r;
            use_addr = 1'b1;
          end
          default: begin
            x = reg_get(reg_hi(dr_r), acc_r, fp_r, sp_r);
            y = reg_get(reg_lo(dr_r), acc_r, fp_r, sp_r);
            use_addr = 1'b1;
          end
        endcase
      end
      CK_SPM1: begin
        x = sp_r;
        y = 32'hFFFF_FFFF;
        use_addr = 1'b1;
      end
      CK_SPM2: begin
        x = sp_r;
        y = 32'hFFFF_FFFE;
        use_addr = 1'b1;
      end
      CK_SP: begin
        x = sp_r;
        use_addr = 1'b1;
        is_read = 1'b1;
        rtag = TG_A;
      end
      CK_FP: begin
        x = fp_r;
        use_addr = 1'b1;
        is_read = 1'b1;
        rtag = TG_X1;
      end
      CK_FP1: begin
        x = fp_r;
        y = 32'd1;
        use_addr = 1'b1;
        is_read = 1'b1;
        rtag = TG_X2;
      end
      CK_TREG: bad = (dr_r > REGS_MAX);
      default: bad = 1'b0;
    endcase
    sum    = {{2{x[31]}}, x} + {{2{y[31]}}, y};
    in_rng = !sum[33] && (sum[32:0] < 33'(STACK_DEPTH));
    idx    = sum[AW-1:0];
    if (bad)
      ck_st = ST_BAD;
    else if (use_addr && !in_rng)
      ck_st = ST_RANGE;
    else
      ck_st = ST_OK;
  end

  assign result = (op_r == OP_DIV) ? div_q : res_r;
  assign fin_ok = (cmd.commit && (op_r != OP_CALL)) || cmd.commit2;

  always_comb begin
    we    = 1'b0;
    waddr = clr_cnt_r;
    wdata = '0;
    if (cmd.clr_we) begin
      we = 1'b1;
    end else if (cmd.commit) begin
      if (op_r >= OP_LT && op_r <= OP_DIV && !to_reg_r) begin
        we    = 1'b1;
        waddr = idx_d_r;
        wdata = result;
      end else if (op_r == OP_CALL) begin
        we    = 1'b1;
        waddr = idx1_r;
        wdata = pc_ext;
      end else if (op_r == OP_PARAM) begin
        we    = 1'b1;
        waddr = idx1_r;
        wdata = a_r;
      end
    end else if (cmd.commit2) begin
      we    = 1'b1;
      waddr = idx2_r;
      wdata = fp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we)
      mem[waddr] <= wdata;
    if (is_read && ck_st == ST_OK)
      rdata_r <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r     <= TG_NONE;
      clr_cnt_r <= '0;
    end else begin
      tag_r <= (is_read && ck_st == ST_OK) ? rtag : TG_NONE;
      if (cmd.clr_we)
        clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // operand capture, direct values now, memory words in the following cycle
  always_ff @(posedge clk) begin
    if (cmd.chk == CK_SRCA && ck_st == ST_OK && !use_addr)
      a_r <= dval;
    else if (tag_r == TG_A)
      a_r <= rdata_r;
    if (cmd.chk == CK_SRCB && ck_st == ST_OK && !use_addr)
      b_r <= dval;
    else if (tag_r == TG_B)
      b_r <= rdata_r;
    if (tag_r == TG_X1)
      x1_r <= rdata_r;
    if (tag_r == TG_X2)
      x2_r <= rdata_r;
    if (cmd.chk == CK_DST) begin
      to_reg_r <= (dm_r == DM_REG);
      idx_d_r  <= idx;
    end
    if (cmd.chk == CK_SPM1)
      idx1_r <= idx;
    if (cmd.chk == CK_SPM2)
      idx2_r <= idx;
    if (cmd.calc) begin
      unique case (op_r)
        OP_LT:   res_r <= {31'd0, $signed(a_r) <  $signed(b_r)};
        OP_GT:   res_r <= {31'd0, $signed(a_r) >  $signed(b_r)};
        OP_LE:   res_r <= {31'd0, $signed(a_r) <= $signed(b_r)};
        OP_GE:   res_r <= {31'd0, $signed(a_r) >= $signed(b_r)};
        OP_EQ:   res_r <= {31'd0, a_r == b_r};
        OP_NE:   res_r <= {31'd0, a_r != b_r};
        OP_ADD:  res_r <= a_r + b_r;
        OP_SUB:  res_r <= a_r - b_r;
        OP_MUL:  res_r <= a_r * b_r;
        default: res_r <= a_r;
      endcase
    end
  end

  assign pc_inc  = pc_r + PC_BITS'(1);
  assign tr      = reg_hi(dr_r);
  assign tr_val  = reg_get(tr, acc_r, fp_r, sp_r);
  assign x2p1    = x2_r + 32'd1;
  assign pc_ext  = 32'(pc_r);
  assign npc_ext = 32'(pc_nxt);

  always_comb begin
    acc_nxt  = acc_r;
    fp_nxt   = fp_r;
    sp_nxt   = sp_r;
    pc_nxt   = pc_r;
    halt_nxt = halt_r;
    if (cmd.fin_err && cmd.err == ST_HALT)
      halt_nxt = 1'b1;
    if (fin_ok) begin
      pc_nxt = pc_inc;
      unique case (op_r)
        OP_LT, OP_GT, OP_LE, OP_GE, OP_EQ, OP_NE, OP_MOVE,
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          if (to_reg_r) begin
            unique case (reg_hi(dr_r))
              2'd0:    acc_nxt = result;
              2'd1:    fp_nxt  = result;
              default: sp_nxt  = result;
            endcase
          end
        end
        OP_GOTO: pc_nxt = dv_r[PC_BITS-1:0];
        OP_SUBREG, OP_ADDREG: begin
          unique case (tr)
            2'd0:    acc_nxt = (op_r == OP_SUBREG) ? tr_val - av_r : tr_val + av_r;
            2'd1:    fp_nxt  = (op_r == OP_SUBREG) ? tr_val - av_r : tr_val + av_r;
            default: sp_nxt  = (op_r == OP_SUBREG) ? tr_val - av_r : tr_val + av_r;
          endcase
        end
        OP_IF: begin
          if (a_r != 32'd0)
            pc_nxt = dv_r[PC_BITS-1:0];
        end
        OP_CALL: begin
          sp_nxt = sp_r - 32'd2;
          fp_nxt = sp_r - 32'd2;
          pc_nxt = dv_r[PC_BITS-1:0];
        end
        OP_IN:  acc_nxt = con_r;
        OP_OUT: sp_nxt  = sp_r + 32'd1;
        OP_RET: begin
          if (am_r != MD_ABSENT)
            acc_nxt = a_r;
          sp_nxt = fp_r + 32'd2;
          fp_nxt = x1_r;
          pc_nxt = x2p1[PC_BITS-1:0];
        end
        OP_PARAM: sp_nxt = sp_r - 32'd1;
        OP_ALLOC: begin
          sp_nxt = sp_r - av_r;
          fp_nxt = fp_r - av_r;
        end
        default: pc_nxt = pc_inc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      fp_r   <= 32'(STACK_DEPTH - 1);
      sp_r   <= 32'(STACK_DEPTH - 1);
      pc_r   <= '0;
      halt_r <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      fp_r   <= fp_nxt;
      sp_r   <= sp_nxt;
      pc_r   <= pc_nxt;
      halt_r <= halt_nxt;
    end
  end

  // result register
  logic [15:0] onpc_r;
  logic        oval_r;
  logic [31:0] ovalue_r;
  logic [2:0]  ost_r;

  always_ff @(posedge clk) begin
    if (fin_ok) begin
      onpc_r   <= npc_ext[15:0];
      oval_r   <= (op_r == OP_OUT);
      ovalue_r <= (op_r == OP_OUT) ? a_r : 32'd0;
      ost_r    <= ST_OK;
    end else if (cmd.fin_err) begin
      onpc_r   <= pc_ext[15:0];
      oval_r   <= 1'b0;
      ovalue_r <= '0;
      ost_r    <= cmd.err;
    end
  end

  assign out_data = {4'd0, ost_r, ovalue_r, oval_r, onpc_r};

  assign stat.op       = op_r;
  assign stat.a_mode   = am_r;
  assign stat.halted   = halt_r;
  assign stat.chk_st   = ck_st;
  assign stat.b_zero   = (b_r == 32'd0);
  assign stat.div_done = div_done;
  assign stat.clr_last = (clr_cnt_r == AW'(STACK_DEPTH - 1));

endmodule

### rtl/tasvm_ctrl.sv
// tasvm_ctrl: sequencer for the executor, drives datapath commands
// depends on tasvm_pkg
module tasvm_ctrl
  import tasvm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DEC    = 4'd2;
  localparam logic [3:0] S_CK1    = 4'd3;
  localparam logic [3:0] S_CK2    = 4'd4;
  localparam logic [3:0] S_CK3    = 4'd5;
  localparam logic [3:0] S_EXEC   = 4'd6;
  localparam logic [3:0] S_CALC   = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_COMMIT = 4'd9;
  localparam logic [3:0] S_WR2    = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0] state_r, state_nxt;

  // which check runs in each of the check states S_CK1, S_CK2 and S_CK3
  function automatic logic [3:0] chk_of(input logic [4:0] op, input logic [2:0] am,
                                        input logic [1:0] n);
    logic [3:0] c;
    logic       alu;
    c   = CK_NONE;
    alu = (op >= OP_LT) && (op <= OP_DIV);
    unique case (n)
      2'd1: begin
        if (alu || op == OP_IF || op == OP_PARAM)    c = CK_SRCA;
        else if (op == OP_SUBREG || op == OP_ADDREG) c = CK_TREG;
        else if (op == OP_CALL)                      c = CK_SPM1;
        else if (op == OP_OUT)                       c = CK_SP;
        else if (op == OP_RET && am != MD_ABSENT)    c = CK_SRCA;
      end
      2'd2: begin
        if (alu && op != OP_MOVE) c = CK_SRCB;
        else if (op == OP_CALL)   c = CK_SPM2;
        else if (op == OP_RET)    c = CK_FP;
        else if (op == OP_PARAM)  c = CK_SPM1;
      end
      2'd3: begin
        if (alu)                c = CK_DST;
        else if (op == OP_RET)  c = CK_FP1;
      end
      default: c = CK_NONE;
    endcase
    return c;
  endfunction

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.err   = ST_OK;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_we = 1'b1;
        if (stat.clr_last)
          state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.load = in_tvalid;
        if (in_tvalid)
          state_nxt = S_DEC;
      end
      S_DEC: begin
        priority if (stat.halted || stat.op == OP_HALT) begin
          cmd.fin_err = 1'b1;
          cmd.err     = ST_HALT;
          state_nxt   = S_OUT;
        end else if (stat.op > OP_HALT) begin
          cmd.fin_err = 1'b1;
          cmd.err     = ST_BAD;
          state_nxt   = S_OUT;
        end else begin
          state_nxt = S_CK1;
        end
      end
      S_CK1, S_CK2, S_CK3: begin
        cmd.chk = chk_of(stat.op, stat.a_mode, 2'(state_r - S_CK1 + 4'd1));
        if (stat.chk_st != ST_OK) begin
          cmd.fin_err = 1'b1;
          cmd.err     = stat.chk_st;
          state_nxt   = S_OUT;
        end else begin
          state_nxt = (state_r == S_CK3) ? S_EXEC : state_r + 4'd1;
        end
      end
      S_EXEC: state_nxt = S_CALC;
      S_CALC: begin
        if (stat.op == OP_DIV) begin
          if (stat.b_zero) begin
            cmd.fin_err = 1'b1;
            cmd.err     = ST_DIV0;
            state_nxt   = S_OUT;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end else begin
          cmd.calc  = 1'b1;
          state_nxt = S_COMMIT;
        end
      end
      S_DIV: begin
        if (stat.div_done)
          state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = (stat.op == OP_CALL) ? S_WR2 : S_OUT;
      end
      S_WR2: begin
        cmd.commit2 = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_tready)
          state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      state_r <= S_CLR;
    else
      state_r <= state_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

endmodule

### rtl/three_address_stack_vm_executor.sv
// channel | dir | tdata bits | contents
// in_     | in  | 160        | one pre-decoded instruction with console input
// out_    | out | 56         | next pc, console output and status
//
// an item passes through decode, checks, exec, calc and commit; call adds a second
// write, and divide runs the bit-serial divider (one quotient bit a cycle)
// after reset a clearing pass writes zero to every stack memory word, one word a
// cycle; in_tready stays low meanwhile
// one instruction at a time: in_tready is low from transfer in to transfer out
// top level: instantiates tasvm_ctrl and tasvm_dp, uses tasvm_pkg
module three_address_stack_vm_executor
  import tasvm_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned PC_BITS     = PC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // opcode, a_mode, a_regs, a_value, b_mode, b_regs, b_value, d_mode, d_regs,
  // d_value, console_in, zero pad
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // next_pc, out_valid, out_value, status, zero pad
  output logic [OUT_W-1:0] out_tdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tasvm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  tasvm_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .PC_BITS     (PC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_tdata)
  );

endmodule

### rtl/tasvm_chk.sv
// tasvm_chk: port-level checks on the executor, bound to the top level
// depends on tasvm_pkg and three_address_stack_vm_executor
module tasvm_chk
  import tasvm_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [IN_W-1:0]  in_tdata,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one instruction in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transfer accepted while busy");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while result pending");

  // console output only on success
  a_out_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] |-> out_tdata[51:49] == ST_OK)
    else $error("output value with error status");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[51:49] != ST_OK |-> out_tdata[48:16] == 33'd0)
    else $error("error result carries output value");

endmodule

bind three_address_stack_vm_executor tasvm_chk u_chk (.*);
